>>> src/tmwo_pkg.sv
// Shared types, sizes, register indexes and helpers for the tile map wall outline block.
// No dependencies; every other file in src imports this package.
package tmwo_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int TILE_BITS  = 4;

   localparam int COL_BITS     = $clog2(MAX_WIDTH);
   localparam int ROW_BITS     = $clog2(MAX_HEIGHT);
   localparam int SIZE_BITS    = 9;
   localparam int POS_BITS     = COL_BITS + ROW_BITS;
   localparam int AREA_BITS    = POS_BITS + 1;
   localparam int DIV_CNT_BITS = $clog2(POS_BITS + 1);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = SIZE_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] REG_MAP_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MAP_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_EMPTY_CODE = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FLOOR_CODE = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_WALL_CODE  = 3'd4;

   localparam int REQ_DATA_BITS = ((TILE_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = TILE_BITS + COL_BITS + ROW_BITS;
   localparam int RSP_DATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;

   typedef logic [TILE_BITS-1:0] tile_type;

   typedef struct packed {
      logic [SIZE_BITS-1:0] map_width;
      logic [SIZE_BITS-1:0] map_height;
      tile_type             empty_code;
      tile_type             floor_code;
      tile_type             wall_code;
   } cfg_type;

   // which sides of the output tile lie on the map border
   typedef struct packed {
      logic left;
      logic right;
      logic top;
      logic bottom;
   } bounds_type;

   typedef struct packed {
      tile_type            tile;
      logic [COL_BITS-1:0] col;
      logic                emit;
      logic                frame_end;
      bounds_type          bounds;
      logic [COL_BITS-1:0] ocol;
      logic [ROW_BITS-1:0] orow;
   } item_type;

   typedef struct packed {
      tile_type up;
      tile_type mid;
      tile_type down;
   } column_type;

   function automatic logic [SIZE_BITS-1:0] clamp_size(input logic [SIZE_BITS-1:0] v,
                                                       input logic [SIZE_BITS-1:0] maxv);
      logic [SIZE_BITS-1:0] r;
      if (v == '0) begin
         r = SIZE_BITS'(1);
      end else if (v > maxv) begin
         r = maxv;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

>>> src/tmwo_front.sv
// Front end: accepts tiles, tracks input and output raster positions, classifies each item.
// Recomputes the output column and row with a serial divider after a register write. Uses tmwo_pkg.
module tmwo_front (
   input  logic               clock,
   input  logic               reset,
   input  tmwo_pkg::cfg_type  cfg,
   input  logic               cfg_write,
   input  logic               req_valid,
   input  logic               req_action,
   input  tmwo_pkg::tile_type req_tile,
   input  logic               queue_ready,
   output logic               req_ready,
   output logic               push,
   output tmwo_pkg::item_type push_item
);
   import tmwo_pkg::*;

   localparam int DIV_BITS = SIZE_BITS + 1;

   logic [SIZE_BITS-1:0] w, h;
   logic [AREA_BITS-1:0] area_ff, area_in;

   logic [COL_BITS-1:0] in_col_ff, in_col_in;
   logic [1:0]          row_ff, row_in;
   logic [POS_BITS-1:0] out_pos_ff, out_pos_in;
   logic [COL_BITS-1:0] ocol_ff, ocol_in;
   logic [ROW_BITS-1:0] orow_ff, orow_in;

   logic                    div_busy_ff;
   logic [DIV_CNT_BITS-1:0] div_cnt_ff;
   logic [SIZE_BITS-1:0]    div_rem_ff;
   logic [POS_BITS-1:0]     div_quo_ff;
   logic [DIV_BITS-1:0]     div_shift, div_diff;
   logic                    div_ge;

   logic lead, past, last, emit, restart, col_wrap, ocol_wrap;
   logic [AREA_BITS-1:0] pos_next;

   assign w       = clamp_size(cfg.map_width, SIZE_BITS'(MAX_WIDTH));
   assign h       = clamp_size(cfg.map_height, SIZE_BITS'(MAX_HEIGHT));
   assign area_in = AREA_BITS'(w) * AREA_BITS'(h);

   assign req_ready = !div_busy_ff && queue_ready;
   assign push      = req_valid && req_ready;

   // no result until one row plus one tile has gone in
   assign lead = (row_ff == 2'd0) ? (SIZE_BITS'(in_col_ff) <= w)
                                  : ((row_ff == 2'd1) && (in_col_ff == '0));
   assign past      = AREA_BITS'(out_pos_ff) >= area_ff;
   assign pos_next  = AREA_BITS'(out_pos_ff) + AREA_BITS'(1);
   assign last      = pos_next == area_ff;
   assign emit      = !lead && !past;
   assign restart   = (!lead && past) || (emit && last);
   assign col_wrap  = (SIZE_BITS'(in_col_ff) + SIZE_BITS'(1)) >= w;
   assign ocol_wrap = (SIZE_BITS'(ocol_ff) + SIZE_BITS'(1)) == w;

   always_comb begin
      push_item.tile          = req_action ? cfg.empty_code : req_tile;
      push_item.col           = in_col_ff;
      push_item.emit          = emit;
      push_item.frame_end     = last;
      push_item.bounds.left   = ocol_ff == '0;
      push_item.bounds.right  = ocol_wrap;
      push_item.bounds.top    = orow_ff == '0;
      push_item.bounds.bottom = (SIZE_BITS'(orow_ff) + SIZE_BITS'(1)) == h;
      push_item.ocol          = ocol_ff;
      push_item.orow          = orow_ff;
   end

   // one restoring step per cycle
   assign div_shift = {div_rem_ff, div_quo_ff[POS_BITS-1]};
   assign div_ge    = div_shift >= DIV_BITS'(w);
   assign div_diff  = div_shift - DIV_BITS'(w);

   always_comb begin
      in_col_in  = in_col_ff;
      row_in     = row_ff;
      out_pos_in = out_pos_ff;
      ocol_in    = ocol_ff;
      orow_in    = orow_ff;
      if (push) begin
         if (col_wrap) begin
            in_col_in = '0;
            if (row_ff != 2'd2) begin
               row_in = row_ff + 2'd1;
            end
         end else begin
            in_col_in = in_col_ff + COL_BITS'(1);
         end
         if (emit) begin
            out_pos_in = out_pos_ff + POS_BITS'(1);
            if (ocol_wrap) begin
               ocol_in = '0;
               orow_in = orow_ff + ROW_BITS'(1);
            end else begin
               ocol_in = ocol_ff + COL_BITS'(1);
            end
         end
         if (restart) begin
            in_col_in  = '0;
            row_in     = '0;
            out_pos_in = '0;
            ocol_in    = '0;
            orow_in    = '0;
         end
      end else if (div_busy_ff && (div_cnt_ff == '0)) begin
         ocol_in = div_rem_ff[COL_BITS-1:0];
         orow_in = div_quo_ff[ROW_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      area_ff <= area_in;
      if (reset) begin
         in_col_ff   <= '0;
         row_ff      <= '0;
         out_pos_ff  <= '0;
         ocol_ff     <= '0;
         orow_ff     <= '0;
         div_busy_ff <= 1'b0;
         div_cnt_ff  <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         row_ff     <= row_in;
         out_pos_ff <= out_pos_in;
         ocol_ff    <= ocol_in;
         orow_ff    <= orow_in;
         if (cfg_write) begin
            div_busy_ff <= 1'b1;
            div_cnt_ff  <= DIV_CNT_BITS'(POS_BITS);
         end else if (div_busy_ff) begin
            if (div_cnt_ff == '0) begin
               div_busy_ff <= 1'b0;
            end else begin
               div_cnt_ff <= div_cnt_ff - DIV_CNT_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cfg_write) begin
         div_rem_ff <= '0;
         div_quo_ff <= out_pos_ff;
      end else if (div_busy_ff && (div_cnt_ff != '0)) begin
         div_rem_ff <= div_ge ? div_diff[SIZE_BITS-1:0] : div_shift[SIZE_BITS-1:0];
         div_quo_ff <= {div_quo_ff[POS_BITS-2:0], div_ge};
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      push && emit |-> (SIZE_BITS'(ocol_ff) < w) && (SIZE_BITS'(orow_ff) < h))
      else $error("emitted tile lies outside the map");

   assert property (@(posedge clock) disable iff (reset)
      push && restart |=> (out_pos_ff == '0) && (in_col_ff == '0) && (row_ff == '0))
      else $error("position counters did not restart");

endmodule

>>> src/tmwo_fifo.sv
// Short item queue between the front end and the back end.
// Holds classified items so either side can stall alone. Uses tmwo_pkg.
module tmwo_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tmwo_pkg::item_type push_item,
   output logic               push_ready,
   input  logic               pop,
   output logic               pop_valid,
   output tmwo_pkg::item_type pop_item
);
   import tmwo_pkg::*;

   item_type                entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [QCOUNT_BITS-1:0]  count_ff;

   assign push_ready = count_ff != QCOUNT_BITS'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_BITS'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + QCOUNT_BITS'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - QCOUNT_BITS'(1);
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (push |-> push_ready) and (pop |-> pop_valid))
      else $error("queue overrun or underrun");

endmodule

>>> src/tmwo_back.sv
// Back end: two line stores, the 3x3 window and the wall decision, plus the result register.
// Takes items from tmwo_fifo. Uses tmwo_pkg.
module tmwo_back (
   input  logic                         clock,
   input  logic                         reset,
   input  tmwo_pkg::cfg_type            cfg,
   input  logic                         q_valid,
   input  tmwo_pkg::item_type           q_item,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output tmwo_pkg::tile_type           rsp_tile,
   output logic [tmwo_pkg::COL_BITS-1:0] rsp_col,
   output logic [tmwo_pkg::ROW_BITS-1:0] rsp_row,
   output logic                         rsp_last
);
   import tmwo_pkg::*;

   tile_type store_a [MAX_WIDTH];
   tile_type store_b [MAX_WIDTH];
   tile_type rd_a_ff, rd_b_ff;

   logic     s1_valid_ff;
   item_type s1_item_ff;

   logic                fwd_valid_ff;
   logic [COL_BITS-1:0] fwd_col_ff;
   tile_type            fwd_a_ff, fwd_b_ff;

   column_type win_mid_ff, win_right_ff;
   column_type left_col, centre_col, right_col;

   logic       en, hit, near_floor;
   tile_type   up1, up2, result;
   bounds_type b;
   tile_type   rsp_tile_ff;
   logic [COL_BITS-1:0] rsp_col_ff;
   logic [ROW_BITS-1:0] rsp_row_ff;
   logic       rsp_valid_ff, rsp_last_ff;

   assign en    = !rsp_valid_ff || rsp_ready;
   assign q_pop = en && q_valid;

   // the store write of the item just ahead lands on the same edge as this read
   assign hit = fwd_valid_ff && (fwd_col_ff == s1_item_ff.col);
   assign up1 = hit ? fwd_a_ff : rd_a_ff;
   assign up2 = hit ? fwd_b_ff : rd_b_ff;

   assign left_col   = win_mid_ff;
   assign centre_col = win_right_ff;
   always_comb begin
      right_col.up   = up2;
      right_col.mid  = up1;
      right_col.down = s1_item_ff.tile;
   end

   assign b = s1_item_ff.bounds;
   always_comb begin
      near_floor = (!b.left && !b.top && (left_col.up == cfg.floor_code))
                || (!b.left && (left_col.mid == cfg.floor_code))
                || (!b.left && !b.bottom && (left_col.down == cfg.floor_code))
                || (!b.top && (centre_col.up == cfg.floor_code))
                || (!b.bottom && (centre_col.down == cfg.floor_code))
                || (!b.right && !b.top && (right_col.up == cfg.floor_code))
                || (!b.right && (right_col.mid == cfg.floor_code))
                || (!b.right && !b.bottom && (right_col.down == cfg.floor_code));
      result = ((centre_col.mid == cfg.empty_code) && near_floor) ? cfg.wall_code
                                                                  : centre_col.mid;
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rd_a_ff <= store_a[q_item.col];
         rd_b_ff <= store_b[q_item.col];
      end
      if (en && s1_valid_ff) begin
         store_a[s1_item_ff.col] <= s1_item_ff.tile;
         store_b[s1_item_ff.col] <= up1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_item_ff  <= q_item;
         fwd_col_ff  <= s1_item_ff.col;
         fwd_a_ff    <= s1_item_ff.tile;
         fwd_b_ff    <= up1;
         rsp_tile_ff <= result;
         rsp_col_ff  <= s1_item_ff.ocol;
         rsp_row_ff  <= s1_item_ff.orow;
         rsp_last_ff <= s1_item_ff.frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         win_mid_ff   <= '0;
         win_right_ff <= '0;
      end else if (en) begin
         s1_valid_ff  <= q_valid;
         fwd_valid_ff <= s1_valid_ff;
         rsp_valid_ff <= s1_valid_ff && s1_item_ff.emit;
         if (s1_valid_ff) begin
            win_mid_ff   <= centre_col;
            win_right_ff <= right_col;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_tile  = rsp_tile_ff;
   assign rsp_col   = rsp_col_ff;
   assign rsp_row   = rsp_row_ff;
   assign rsp_last  = rsp_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      !en && s1_valid_ff |=> s1_valid_ff && $stable(s1_item_ff) && $stable(win_right_ff))
      else $error("window stage moved during a result stall");

endmodule

>>> src/tile_map_wall_outline.sv
// Top level of the tile map wall outline block: register file, port packing, sub-blocks.
// Instantiates tmwo_front, tmwo_fifo and tmwo_back; uses tmwo_pkg.
//
//   channel  direction  ports                                 moves
//   req      in         req_tvalid/tready, tdata, tuser       one map tile or flush item
//   rsp      out        rsp_tvalid/tready, tdata, tlast       one finished tile
//   csr      in         csr_valid/ready, csr_index, csr_data  one register write
//
// One item per cycle unless rsp_tready is low or the divider is busy; results are registered.
// Results trail the input by one map row plus one tile; that many flush items drain a frame.
// After each register write the front runs a 16-step divider to rebuild the output
// column and row, and holds req_tready low while it runs.
// Synchronous active-high reset clears counters, window and valid flags; line stores
// are not cleared. A stalled rsp side backs up through a 4-entry queue to req_tready.
module tile_map_wall_outline (
   input  logic                              clock,
   input  logic                              reset,
   // req: tdata = tile_in[3:0], zero padded; tuser = action
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [tmwo_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  logic                              req_tuser,
   // rsp: tdata = tile_out[3:0], out_col[11:4], out_row[19:12], zero padded; tlast = frame_end
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [tmwo_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                              rsp_tlast,
   // csr: register write port
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tmwo_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [tmwo_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import tmwo_pkg::*;

   cfg_type  cfg_ff;
   logic     csr_write;

   logic     push, queue_ready, q_valid, q_pop;
   item_type push_item, q_item;

   tile_type            rsp_tile;
   logic [COL_BITS-1:0] rsp_col;
   logic [ROW_BITS-1:0] rsp_row;

   // writes are always taken; the host must write only while the block is idle; not enforced
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.map_width  <= SIZE_BITS'(128);
         cfg_ff.map_height <= SIZE_BITS'(128);
         cfg_ff.empty_code <= TILE_BITS'(0);
         cfg_ff.floor_code <= TILE_BITS'(1);
         cfg_ff.wall_code  <= TILE_BITS'(2);
      end else if (csr_write) begin
         unique case (csr_index)
            REG_MAP_WIDTH:  cfg_ff.map_width  <= csr_data[SIZE_BITS-1:0];
            REG_MAP_HEIGHT: cfg_ff.map_height <= csr_data[SIZE_BITS-1:0];
            REG_EMPTY_CODE: cfg_ff.empty_code <= csr_data[TILE_BITS-1:0];
            REG_FLOOR_CODE: cfg_ff.floor_code <= csr_data[TILE_BITS-1:0];
            REG_WALL_CODE:  cfg_ff.wall_code  <= csr_data[TILE_BITS-1:0];
            default: begin
               // drop writes to unused indexes
            end
         endcase
      end
   end

   // classify: position tracking, lead-in and frame end
   tmwo_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .cfg_write   (csr_write),
      .req_valid   (req_tvalid),
      .req_action  (req_tuser),
      .req_tile    (req_tdata[TILE_BITS-1:0]),
      .queue_ready (queue_ready),
      .req_ready   (req_tready),
      .push        (push),
      .push_item   (push_item)
   );

   tmwo_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .push_ready (queue_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_item   (q_item)
   );

   // execute: line stores, window, wall decision, result register
   tmwo_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_tile  (rsp_tile),
      .rsp_col   (rsp_col),
      .rsp_row   (rsp_row),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tdata = {(RSP_DATA_BITS - RSP_FIELD_BITS)'(0), rsp_row, rsp_col, rsp_tile};

endmodule

>>> bench/tb_top.sv
// Self-checking bench for tile_map_wall_outline: streams tile frames, predicts each outlined tile.
// Depends on tmwo_pkg for widths and register indexes; the DUT and its sub-blocks are the other files.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import tmwo_pkg::*;

   // action field of a request transfer
   localparam logic ACT_TILE  = 1'b0;
   localparam logic ACT_FLUSH = 1'b1;

   // index with no register behind it; a write there must change nothing
   localparam logic [CSR_INDEX_BITS-1:0] REG_UNUSED = 3'd7;

   // cycles without any transfer before the run is declared hung
   localparam int STALL_LIMIT = 2000;
   // cycles the receiver holds off once so the DUT backs up into req_tready
   localparam int HOLDOFF_CYCLES = 300;
   // settle time after the last result before touching registers or ending
   localparam int SETTLE_CYCLES = 8;

   typedef enum int {PACE_NONE, PACE_SEND, PACE_RECV, PACE_BOTH} pace_type;

   typedef struct packed {
      logic     action;
      tile_type code;
   } map_item_type;

   typedef struct packed {
      tile_type            tile;
      logic [COL_BITS-1:0] col;
      logic [ROW_BITS-1:0] row;
      logic                last;
   } placed_tile_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_BITS-1:0]  req_tdata = '0;
   logic                      req_tuser = ACT_TILE;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                      rsp_tlast;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = REG_MAP_WIDTH;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   // stimulus and expectation stores
   map_item_type    pending_items[$];
   placed_tile_type tiles_due[$];
   int              mismatches = 0;
   logic            req_fire = 1'b0;

   // pacing knobs, set per phase by the sequencer
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int unsigned rx_cycle = 0;
   int unsigned holdoff_until = 0;

   // predictor copy of the register file
   logic [CSR_DATA_BITS-1:0] cfg_width  = 9'd128;
   logic [CSR_DATA_BITS-1:0] cfg_height = 9'd128;
   tile_type                 cfg_empty  = 4'd0;
   tile_type                 cfg_floor  = 4'd1;
   tile_type                 cfg_wall   = 4'd2;

   // predictor state: two line stores, 3x3 window [column][row], positions
   tile_type above1 [MAX_WIDTH];
   tile_type above2 [MAX_WIDTH];
   tile_type win [3][3];
   int       in_x = 0;
   int       in_y = 0;
   int       out_idx = 0;

   tile_map_wall_outline i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // size register as the block sees it: zero acts as one, oversize saturates
   function automatic int eff_size(input logic [CSR_DATA_BITS-1:0] v, input int limit);
      if (v == '0) begin
         return 1;
      end
      if (int'(v) > limit) begin
         return limit;
      end
      return int'(v);
   endfunction

   // Advance the outline predictor by one accepted item and queue the tile it releases.
   task automatic outline_step(input logic action, input tile_type code);
      int              w, h, q, c, ocol, orow, dc, dr, nc, nr, k;
      tile_type        tile, up1, up2, res;
      placed_tile_type due;
      w = eff_size(cfg_width, MAX_WIDTH);
      h = eff_size(cfg_height, MAX_HEIGHT);
      // a flush item counts as an empty tile
      tile = (action == ACT_FLUSH) ? cfg_empty : code;
      c = (in_x < MAX_WIDTH) ? in_x : 0;
      up1 = above1[c];
      up2 = above2[c];
      q = in_y * w + in_x;
      above2[c] = up1;
      above1[c] = tile;
      for (k = 0; k < 2; k++) begin
         win[k] = win[k+1];
      end
      win[2][0] = up2;
      win[2][1] = up1;
      win[2][2] = tile;
      if (in_x + 1 >= w) begin
         in_x = 0;
         in_y++;
      end else begin
         in_x++;
      end
      // nothing leaves until one row plus one tile has arrived
      if (q < w + 1) begin
         return;
      end
      if (out_idx >= w * h) begin
         in_x = 0;
         in_y = 0;
         out_idx = 0;
         return;
      end
      ocol = out_idx % w;
      orow = out_idx / w;
      res = win[1][1];
      // judge neighbors on original codes only, so walls never spread
      if (win[1][1] == cfg_empty) begin
         for (dc = -1; dc <= 1; dc++) begin
            for (dr = -1; dr <= 1; dr++) begin
               nc = ocol + dc;
               nr = orow + dr;
               if (!(dc == 0 && dr == 0) && nc >= 0 && nr >= 0 && nc < w && nr < h &&
                   win[dc+1][dr+1] == cfg_floor) begin
                  res = cfg_wall;
               end
            end
         end
      end
      out_idx++;
      due.tile = res;
      due.col  = COL_BITS'(ocol);
      due.row  = ROW_BITS'(orow);
      due.last = (out_idx == w * h);
      tiles_due.push_back(due);
      if (due.last) begin
         in_x = 0;
         in_y = 0;
         out_idx = 0;
      end
   endtask

   // Sample both streams at the rising edge: check results first, then predict.
   always @(posedge clock) begin : monitor
      placed_tile_type got, want;
      req_fire <= !reset && req_tvalid && req_tready;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.tile = rsp_tdata[TILE_BITS-1:0];
         got.col  = rsp_tdata[TILE_BITS +: COL_BITS];
         got.row  = rsp_tdata[TILE_BITS+COL_BITS +: ROW_BITS];
         got.last = rsp_tlast;
         if (tiles_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: unexpected tile %0d at col %0d row %0d last %0b",
                        $realtime, got.tile, got.col, got.row, got.last);
            end
         end else begin
            want = tiles_due.pop_front();
            if (got.tile !== want.tile || got.col !== want.col || got.row !== want.row ||
                got.last !== want.last) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: expected tile %0d col %0d row %0d last %0b", $realtime,
                           want.tile, want.col, want.row, want.last);
                  $display("%0t:   actual tile %0d col %0d row %0d last %0b", $realtime,
                           got.tile, got.col, got.row, got.last);
               end
            end
         end
      end
      if (!reset && req_tvalid && req_tready) begin
         outline_step(req_tuser, req_tdata[TILE_BITS-1:0]);
      end
   end

   // Request driver: drop the item just transferred, then hold or offer the next one.
   always @(negedge clock) begin
      if (req_fire) begin
         pending_items.delete(0);
      end
      if (!req_tvalid || req_fire) begin
         if (pending_items.size() > (req_fire ? 1 : 0) - (req_fire ? 1 : 0) &&
             pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tuser  <= pending_items[0].action;
            req_tdata  <= REQ_DATA_BITS'(pending_items[0].code);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result receiver: honor a pending hold-off, otherwise stall at random.
   always @(negedge clock) begin
      rx_cycle++;
      if (rx_cycle < holdoff_until) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Watchdog: end the run if no transfer of any kind happens for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("end of test: mismatches");
      $finish;
   end

   task automatic set_pace(input pace_type pace);
      send_idle_pct = (pace == PACE_SEND) ? 52 : (pace == PACE_BOTH) ? 14 : 0;
      rsp_stall_pct = (pace == PACE_RECV) ? 52 : (pace == PACE_BOTH) ? 14 : 0;
   endtask

   // One register transfer; mirror it into the predictor once accepted.
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      case (idx)
         REG_MAP_WIDTH:  cfg_width  = value;
         REG_MAP_HEIGHT: cfg_height = value;
         REG_EMPTY_CODE: cfg_empty  = value[TILE_BITS-1:0];
         REG_FLOOR_CODE: cfg_floor  = value[TILE_BITS-1:0];
         REG_WALL_CODE:  cfg_wall   = value[TILE_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_map(input int w, input int h, input int e, input int f, input int wl);
      write_reg(REG_MAP_WIDTH,  CSR_DATA_BITS'(w));
      write_reg(REG_MAP_HEIGHT, CSR_DATA_BITS'(h));
      write_reg(REG_EMPTY_CODE, CSR_DATA_BITS'(e));
      write_reg(REG_FLOOR_CODE, CSR_DATA_BITS'(f));
      write_reg(REG_WALL_CODE,  CSR_DATA_BITS'(wl));
   endtask

   task automatic push_item(input logic action, input tile_type code);
      pending_items.push_back('{action, code});
   endtask

   // One well-formed frame with random content, then its drain.
   task automatic push_frame();
      int w, h, k, roll;
      w = eff_size(cfg_width, MAX_WIDTH);
      h = eff_size(cfg_height, MAX_HEIGHT);
      for (k = 0; k < w * h; k++) begin
         roll = $urandom_range(99);
         if (roll < 10) begin
            push_item(ACT_FLUSH, tile_type'($urandom_range(15)));
         end else if (roll < 50) begin
            push_item(ACT_TILE, cfg_empty);
         end else if (roll < 85) begin
            push_item(ACT_TILE, cfg_floor);
         end else begin
            push_item(ACT_TILE, tile_type'($urandom_range(15)));
         end
      end
      // drain: flush items mixed with tiles that land past the map
      for (k = 0; k <= w; k++) begin
         push_item(($urandom_range(3) == 0) ? ACT_TILE : ACT_FLUSH,
                   tile_type'($urandom_range(15)));
      end
   endtask

   // Hold the sequencer until every item went in and every result came back.
   task automatic wait_drained();
      while (pending_items.size() != 0 || req_tvalid || tiles_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : sequencer
      int p, k, frames, w, h, e, f;
      for (k = 0; k < MAX_WIDTH; k++) begin
         above1[k] = '0;
         above2[k] = '0;
      end
      for (k = 0; k < 9; k++) begin
         win[k/3][k%3] = '0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // 3x3, floor is the top code and empty the bottom one; one floor in the corner
      // must outline only its three neighbors, the far corner keeps a foreign code
      set_pace(PACE_NONE);
      set_map(3, 3, 0, 15, 9);
      push_item(ACT_TILE, 4'd15); push_item(ACT_TILE, 4'd0); push_item(ACT_TILE, 4'd0);
      push_item(ACT_TILE, 4'd0);  push_item(ACT_TILE, 4'd0); push_item(ACT_TILE, 4'd0);
      push_item(ACT_TILE, 4'd0);  push_item(ACT_TILE, 4'd0); push_item(ACT_TILE, 4'd7);
      for (k = 0; k < 4; k++) begin
         push_item(ACT_FLUSH, 4'd0);
      end
      wait_drained();

      // 4x2 with codes swapped: flush items inside the map stand for empty tiles,
      // floor tiles sent past the map must not outline anything
      set_pace(PACE_BOTH);
      set_map(4, 2, 15, 0, 5);
      write_reg(REG_UNUSED, 9'h1ff);
      push_item(ACT_TILE, 4'd15); push_item(ACT_FLUSH, 4'd9);  push_item(ACT_TILE, 4'd0);
      push_item(ACT_TILE, 4'd15);
      push_item(ACT_TILE, 4'd15); push_item(ACT_TILE, 4'd15);  push_item(ACT_FLUSH, 4'd0);
      push_item(ACT_TILE, 4'd3);
      push_item(ACT_TILE, 4'd0);  push_item(ACT_FLUSH, 4'd6);  push_item(ACT_TILE, 4'd0);
      push_item(ACT_FLUSH, 4'd0); push_item(ACT_TILE, 4'd15);
      wait_drained();

      // size extremes: one column of the tallest map (oversize height saturates),
      // a long single row, and zero sizes acting as a 1x1 map
      set_pace(PACE_SEND);
      set_map(1, 511, 0, 1, 2);
      push_frame();
      wait_drained();

      set_pace(PACE_RECV);
      set_map(128, 1, $urandom_range(15), $urandom_range(15), $urandom_range(15));
      push_frame();
      wait_drained();

      set_pace(PACE_BOTH);
      set_map(0, 0, 3, 4, 5);
      for (k = 0; k < 6; k++) begin
         push_frame();
      end
      wait_drained();

      // random small maps; the first phase also holds the result side off for a
      // long stretch while items keep coming, so the block backs up its input
      for (p = 0; p < 6; p++) begin
         w = $urandom_range(2, 12);
         h = $urandom_range(1, 8);
         e = $urandom_range(15);
         f = ($urandom_range(9) == 0) ? e : $urandom_range(15);
         set_map(w, h, e, f, $urandom_range(15));
         if (p == 0) begin
            set_pace(PACE_NONE);
            holdoff_until = rx_cycle + HOLDOFF_CYCLES;
         end else begin
            set_pace(pace_type'(p % 4));
         end
         frames = (w * h >= 20) ? 1 : 20 / (w * h);
         for (k = 0; k < frames; k++) begin
            push_frame();
         end
         wait_drained();
      end

      if (mismatches == 0 && tiles_due.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

>>> sim.f
src/tmwo_pkg.sv
src/tmwo_front.sv
src/tmwo_fifo.sv
src/tmwo_back.sv
src/tile_map_wall_outline.sv
bench/tb_top.sv
